// ===== hdl/lnz_pkg.sv =====
package lnz_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int HASH_BITS  = 30;
  localparam int NUM_HASH   = 4;
  localparam int NUM_STAGES = 14;
  localparam int HW         = FRAC_BITS + 4;
  localparam int SPLIT_W    = (2 * FRAC_BITS + 32 > 64) ? 2 * FRAC_BITS + 32 : 64;

  localparam int HASH_SHIFT   = 13;
  localparam logic [31:0] HASH_C1 = 32'd15731;
  localparam logic [31:0] HASH_C2 = 32'd789221;
  localparam logic [31:0] HASH_C3 = 32'd1376312589;

  localparam logic [31:0] HASH_MUL [NUM_HASH][3] = '{
    '{32'd67,  32'd59,  32'd71},
    '{32'd73,  32'd79,  32'd83},
    '{32'd89,  32'd97,  32'd101},
    '{32'd103, 32'd107, 32'd109}
  };

  typedef enum logic [2:0] {
    REG_FREQ_X    = 3'd0,
    REG_FREQ_Y    = 3'd1,
    REG_FREQ_Z    = 3'd2,
    REG_PHASE_X   = 3'd3,
    REG_PHASE_Y   = 3'd4,
    REG_PHASE_Z   = 3'd5,
    REG_AMPLITUDE = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic mul;
    logic sub;
  } split_en_t;

  typedef struct packed {
    logic sum;
    logic sq;
    logic mix;
    logic fin;
  } hash_en_t;

  typedef struct packed {
    logic mul;
    logic add;
  } blend_en_t;

  typedef struct packed {
    logic [FRAC_BITS-1:0] t;
    logic signed [HW-1:0] h00;
    logic signed [HW-1:0] h01;
    logic signed [HW-1:0] h10;
    logic signed [HW-1:0] h11;
  } basis_t;

endpackage

// ===== hdl/lnz_split.sv =====
module lnz_split import lnz_pkg::*; (
  input  logic                  clk_i,
  input  split_en_t             en_i,
  input  logic signed [31:0]    coord_i,
  input  logic signed [31:0]    freq_i,
  input  logic signed [31:0]    phase_i,
  output logic [31:0]           cell0_o,
  output logic [31:0]           cell1_o,
  output logic [FRAC_BITS-1:0]  frac_o
);

  logic signed [63:0]        prod_q;
  logic signed [SPLIT_W-1:0] scaled;
  logic [31:0]               lat_idx;

  always_comb begin
    scaled  = SPLIT_W'(prod_q) - (SPLIT_W'(phase_i) <<< (FRAC_BITS + 1));
    lat_idx = scaled[2*FRAC_BITS+31:2*FRAC_BITS];
  end

  always_ff @(posedge clk_i) begin
    if (en_i.mul) begin
      prod_q <= coord_i * freq_i;
    end
    if (en_i.sub) begin
      cell0_o <= lat_idx;
      cell1_o <= lat_idx + 32'd1;
      frac_o  <= scaled[2*FRAC_BITS-1:FRAC_BITS];
    end
  end

endmodule

// ===== hdl/lnz_hash.sv =====
module lnz_hash import lnz_pkg::*; (
  input  logic               clk_i,
  input  hash_en_t           en_i,
  input  logic [31:0]        x_i,
  input  logic [31:0]        y_i,
  input  logic [31:0]        z_i,
  output logic signed [31:0] val_o [NUM_HASH]
);

  logic [31:0] sum_q [NUM_HASH];
  logic [31:0] s_q   [NUM_HASH];
  logic [31:0] sq_q  [NUM_HASH];
  logic [31:0] s2_q  [NUM_HASH];
  logic [31:0] mix_q [NUM_HASH];
  logic [31:0] s_d   [NUM_HASH];
  logic [31:0] h_d   [NUM_HASH];

  always_comb begin
    for (int k = 0; k < NUM_HASH; k++) begin
      s_d[k] = (sum_q[k] << HASH_SHIFT) ^ sum_q[k];
      h_d[k] = s2_q[k] * mix_q[k] + HASH_C3;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NUM_HASH; k++) begin
      if (en_i.sum) begin
        sum_q[k] <= HASH_MUL[k][0] * x_i + HASH_MUL[k][1] * y_i + HASH_MUL[k][2] * z_i;
      end
      if (en_i.sq) begin
        s_q[k]  <= s_d[k];
        sq_q[k] <= s_d[k] * s_d[k];
      end
      if (en_i.mix) begin
        s2_q[k]  <= s_q[k];
        mix_q[k] <= sq_q[k] * HASH_C1 + HASH_C2;
      end
      if (en_i.fin) begin
        val_o[k] <= (32'sd1 <<< HASH_BITS) - $signed({1'b0, h_d[k][30:0]});
      end
    end
  end

endmodule

// ===== hdl/lnz_blend.sv =====
module lnz_blend import lnz_pkg::*; (
  input  logic               clk_i,
  input  blend_en_t          en_i,
  input  basis_t             basis_i,
  input  logic [1:0]         tan_sel_i,
  input  logic signed [31:0] lo_i  [NUM_HASH],
  input  logic signed [31:0] hi_i  [NUM_HASH],
  output logic signed [31:0] res_o [NUM_HASH]
);

  localparam int LW  = 33 + FRAC_BITS + 1;
  localparam int HPW = 32 + HW;

  logic signed [31:0]    a_q   [3];
  logic signed [LW-1:0]  lp_q  [3];
  logic signed [HPW-1:0] hp_q  [4];
  logic signed [32:0]    diff  [3];
  logic signed [LW-1:0]  lin_sh [3];
  logic signed [HPW+1:0] hsum;
  logic signed [HPW+1:0] hsh;
  logic signed [31:0]    r0;
  logic signed [31:0]    r1;

  always_comb begin
    r0 = lo_i[tan_sel_i];
    r1 = hi_i[tan_sel_i];
    for (int k = 0; k < 3; k++) begin
      diff[k]   = 33'(hi_i[k]) - 33'(lo_i[k]);
      lin_sh[k] = lp_q[k] >>> FRAC_BITS;
    end
    hsum = (HPW+2)'(hp_q[0]) + (HPW+2)'(hp_q[1]) + (HPW+2)'(hp_q[2]) + (HPW+2)'(hp_q[3]);
    hsh  = hsum >>> FRAC_BITS;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.mul) begin
      for (int k = 0; k < 3; k++) begin
        a_q[k]  <= lo_i[k];
        lp_q[k] <= diff[k] * $signed({1'b0, basis_i.t});
      end
      hp_q[0] <= lo_i[3] * basis_i.h00;
      hp_q[1] <= hi_i[3] * basis_i.h01;
      hp_q[2] <= r0 * basis_i.h10;
      hp_q[3] <= r1 * basis_i.h11;
    end
    if (en_i.add) begin
      for (int k = 0; k < 3; k++) begin
        res_o[k] <= 32'(lin_sh[k] + LW'(a_q[k]));
      end
      res_o[3] <= hsh[31:0];
    end
  end

endmodule

// ===== hdl/lattice_noise_3d_eval_top.sv =====
// 3-D lattice gradient noise, one point per beat. Fully pipelined: a new point is taken
// every cycle unless the output stalls. Stages in order: axis scale 2, corner hash 4,
// three axis blends of 2 each, gain and saturation 2. Output back-pressure stalls
// the pipe stage by stage, so empty stages still accept. Configuration writes are always
// accepted and must only be issued while no point is in flight.
module lattice_noise_3d_eval_top import lnz_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,  // coord_x, coord_y, coord_z
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // noise_value
);

  localparam int ONE_F = 1 << FRAC_BITS;

  logic signed [31:0] freq_q  [3];
  logic signed [31:0] phase_q [3];
  logic signed [31:0] amp_q;

  logic [NUM_STAGES:1] valid_q;
  logic [NUM_STAGES:1] rdy;

  logic [31:0]          cell0 [3];
  logic [31:0]          cell1 [3];
  logic [FRAC_BITS-1:0] frac  [3];

  logic [FRAC_BITS-1:0] t3_q   [3];
  logic [FRAC_BITS-1:0] tt3_q  [3];
  logic [FRAC_BITS-1:0] t4_q   [3];
  logic [FRAC_BITS-1:0] tt4_q  [3];
  logic [FRAC_BITS-1:0] ttt4_q [3];
  logic [2*FRAC_BITS-1:0] tsq  [3];
  logic [2*FRAC_BITS-1:0] tcu  [3];
  basis_t bas_d [3];
  basis_t bas_q [5:10][3];

  logic signed [31:0] vals [8][NUM_HASH];
  logic signed [31:0] vx   [4][NUM_HASH];
  logic signed [31:0] vy   [2][NUM_HASH];
  logic signed [31:0] vz   [NUM_HASH];

  logic signed [63:0] gain_q;
  logic signed [63:0] gain_sh;
  logic [31:0]        out_q;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q[0]  <= 32'(ONE_F);
      freq_q[1]  <= 32'(ONE_F);
      freq_q[2]  <= 32'(ONE_F);
      phase_q[0] <= '0;
      phase_q[1] <= '0;
      phase_q[2] <= '0;
      amp_q      <= 32'(ONE_F);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_FREQ_X:    freq_q[0]  <= cfg_data_i;
        REG_FREQ_Y:    freq_q[1]  <= cfg_data_i;
        REG_FREQ_Z:    freq_q[2]  <= cfg_data_i;
        REG_PHASE_X:   phase_q[0] <= cfg_data_i;
        REG_PHASE_Y:   phase_q[1] <= cfg_data_i;
        REG_PHASE_Z:   phase_q[2] <= cfg_data_i;
        REG_AMPLITUDE: amp_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage control
  always_comb begin
    rdy[NUM_STAGES] = !valid_q[NUM_STAGES] || m_axis_tready;
    for (int k = NUM_STAGES - 1; k >= 1; k--) begin
      rdy[k] = !valid_q[k] || rdy[k+1];
    end
  end

  assign s_axis_tready = rdy[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (rdy[1]) begin
        valid_q[1] <= s_axis_tvalid;
      end
      for (int k = 2; k <= NUM_STAGES; k++) begin
        if (rdy[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // axis scaling
  for (genvar a = 0; a < 3; a++) begin : g_split
    lnz_split u_split (
      .clk_i   (clk_i),
      .en_i    ('{mul: rdy[1], sub: rdy[2]}),
      .coord_i ($signed(s_axis_tdata[32*a+31:32*a])),
      .freq_i  (freq_q[a]),
      .phase_i (phase_q[a]),
      .cell0_o (cell0[a]),
      .cell1_o (cell1[a]),
      .frac_o  (frac[a])
    );
  end

  // Hermite basis, runs beside the hash
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      tsq[a] = frac[a] * frac[a];
      tcu[a] = tt3_q[a] * t3_q[a];
      bas_d[a].t   = t4_q[a];
      bas_d[a].h00 = (HW'(ttt4_q[a]) <<< 1) - HW'(3) * HW'(tt4_q[a]) + HW'(ONE_F);
      bas_d[a].h01 = HW'(3) * HW'(tt4_q[a]) - (HW'(ttt4_q[a]) <<< 1);
      bas_d[a].h10 = HW'(ttt4_q[a]) - (HW'(tt4_q[a]) <<< 1) + HW'(t4_q[a]);
      bas_d[a].h11 = HW'(ttt4_q[a]) - HW'(tt4_q[a]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 3; a++) begin
      if (rdy[3]) begin
        t3_q[a]  <= frac[a];
        tt3_q[a] <= tsq[a][2*FRAC_BITS-1:FRAC_BITS];
      end
      if (rdy[4]) begin
        t4_q[a]   <= t3_q[a];
        tt4_q[a]  <= tt3_q[a];
        ttt4_q[a] <= tcu[a][2*FRAC_BITS-1:FRAC_BITS];
      end
    end
    if (rdy[5]) begin
      bas_q[5] <= bas_d;
    end
    for (int k = 6; k <= 10; k++) begin
      if (rdy[k]) begin
        bas_q[k] <= bas_q[k-1];
      end
    end
  end

  // corner hashes
  for (genvar i = 0; i < 8; i++) begin : g_corner
    lnz_hash u_hash (
      .clk_i (clk_i),
      .en_i  ('{sum: rdy[3], sq: rdy[4], mix: rdy[5], fin: rdy[6]}),
      .x_i   ((i % 2 == 1)       ? cell1[0] : cell0[0]),
      .y_i   ((i / 2 % 2 == 1)   ? cell1[1] : cell0[1]),
      .z_i   ((i / 4 % 2 == 1)   ? cell1[2] : cell0[2]),
      .val_o (vals[i])
    );
  end

  // axis reduction
  for (genvar j = 0; j < 4; j++) begin : g_bx
    lnz_blend u_bx (
      .clk_i     (clk_i),
      .en_i      ('{mul: rdy[7], add: rdy[8]}),
      .basis_i   (bas_q[6][0]),
      .tan_sel_i (2'd0),
      .lo_i      (vals[2*j]),
      .hi_i      (vals[2*j+1]),
      .res_o     (vx[j])
    );
  end

  for (genvar j = 0; j < 2; j++) begin : g_by
    lnz_blend u_by (
      .clk_i     (clk_i),
      .en_i      ('{mul: rdy[9], add: rdy[10]}),
      .basis_i   (bas_q[8][1]),
      .tan_sel_i (2'd1),
      .lo_i      (vx[2*j]),
      .hi_i      (vx[2*j+1]),
      .res_o     (vy[j])
    );
  end

  lnz_blend u_bz (
    .clk_i     (clk_i),
    .en_i      ('{mul: rdy[11], add: rdy[12]}),
    .basis_i   (bas_q[10][2]),
    .tan_sel_i (2'd2),
    .lo_i      (vy[0]),
    .hi_i      (vy[1]),
    .res_o     (vz)
  );

  // gain and saturation
  assign gain_sh = gain_q >>> HASH_BITS;

  always_ff @(posedge clk_i) begin
    if (rdy[13]) begin
      gain_q <= vz[3] * amp_q;
    end
    if (rdy[14]) begin
      if (gain_sh > 64'sh0000_0000_7FFF_FFFF) begin
        out_q <= 32'h7FFF_FFFF;
      end else if (gain_sh < -64'sh0000_0000_8000_0000) begin
        out_q <= 32'h8000_0000;
      end else begin
        out_q <= gain_sh[31:0];
      end
    end
  end

  assign m_axis_tvalid = valid_q[NUM_STAGES];
  assign m_axis_tdata  = out_q;

  a_ready_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output is ready");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&valid_q) && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted into a full stalled pipe");

  a_hold_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[6] && !rdy[7] |=> valid_q[6])
    else $error("stalled beat dropped in hash stage");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_q[1] |-> s_axis_tready)
    else $error("empty front stage refuses input");

endmodule
